// File: hdl/uart_baud_divisor_select_unit_macros.svh
// Assertion macros shared by the baud divisor select RTL.
`ifndef UART_BAUD_DIVISOR_SELECT_UNIT_MACROS_SVH
`define UART_BAUD_DIVISOR_SELECT_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define UBDS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define UBDS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define UBDS_ASSERT(lbl, clk, rstn, prop, msg)
`define UBDS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: hdl/ubds_pkg.sv
// Shared constants for the baud divisor select block.
package ubds_pkg;
  localparam int unsigned BaudW       = 24;
  localparam int unsigned ClkW        = 32;
  localparam int unsigned PclkW       = 31;
  localparam int unsigned DivWidthDef = 16;
  localparam int unsigned Shift16     = 4;
  localparam int unsigned Shift4      = 2;
  localparam int unsigned ErrShift    = 5;
  localparam int unsigned DenAW       = BaudW + Shift16;
  localparam logic [ClkW-1:0] ClockReset = 32'd32000000;
  localparam int unsigned TuserHs     = 0;
  localparam int unsigned TuserStatus = 1;
endpackage

// File: hdl/ubds_divider.sv
// Two-lane pipelined restoring divider, one quotient bit per stage, shared dividend.
module ubds_divider #(
  parameter int unsigned NW = 31,
  parameter int unsigned DW = 28,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_a_i,
  input  logic [DW-1:0] divisor_b_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quot_a_o,
  output logic [NW-1:0] quot_b_o,
  output logic [SW-1:0] side_o
);
  logic          vld_q  [0:NW-1];
  logic [NW-1:0] dvd_q  [0:NW-1];
  logic [SW-1:0] side_q [0:NW-1];
  logic [DW-1:0] dvs_q  [0:1][0:NW-1];
  logic [DW-1:0] rem_q  [0:1][0:NW-1];
  logic [NW-1:0] quo_q  [0:1][0:NW-1];
  logic [DW-1:0] dvs_in [0:1];

  assign dvs_in[0] = divisor_a_i;
  assign dvs_in[1] = divisor_b_i;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          p_vld;
    logic [NW-1:0] p_dvd;
    logic [SW-1:0] p_side;
    if (k == 0) begin : g_first
      assign p_vld  = valid_i;
      assign p_dvd  = dividend_i;
      assign p_side = side_i;
    end else begin : g_next
      assign p_vld  = vld_q[k-1];
      assign p_dvd  = dvd_q[k-1];
      assign p_side = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= p_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd_q[k]  <= p_dvd;
        side_q[k] <= p_side;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DW-1:0] p_dvs, p_rem, rem_d;
      logic [NW-1:0] p_quo, quo_d;
      logic [DW:0]   cand, diff;
      logic          ge;
      if (k == 0) begin : g_first
        assign p_dvs = dvs_in[l];
        assign p_rem = '0;
        assign p_quo = '0;
      end else begin : g_next
        assign p_dvs = dvs_q[l][k-1];
        assign p_rem = rem_q[l][k-1];
        assign p_quo = quo_q[l][k-1];
      end

      always_comb begin
        cand = {p_rem, p_dvd[NW-1-k]};
        diff = cand - {1'b0, p_dvs};
        ge   = (cand >= {1'b0, p_dvs});
        rem_d = ge ? diff[DW-1:0] : cand[DW-1:0];
        quo_d = p_quo;
        quo_d[NW-1-k] = ge;
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          dvs_q[l][k] <= p_dvs;
          rem_q[l][k] <= rem_d;
          quo_q[l][k] <= quo_d;
        end
      end
    end
  end

  assign valid_o  = vld_q[NW-1];
  assign quot_a_o = quo_q[0][NW-1];
  assign quot_b_o = quo_q[1][NW-1];
  assign side_o   = side_q[NW-1];
endmodule

// File: hdl/ubds_select.sv
// Error computation, mode choice and rejection check, two register stages.
module ubds_select #(
  parameter int unsigned DIVISOR_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [ubds_pkg::PclkW-1:0] act16_i,
  input  logic [ubds_pkg::PclkW-1:0] act4_i,
  input  logic [DIVISOR_WIDTH-1:0] div16_i,
  input  logic [DIVISOR_WIDTH-1:0] div4_i,
  input  logic [ubds_pkg::BaudW-1:0] baud_i,
  output logic                     valid_o,
  output logic [DIVISOR_WIDTH-1:0] divisor_o,
  output logic                     high_speed_o,
  output logic                     status_o
);
  import ubds_pkg::*;

  logic [PclkW-1:0]          baud_x, e16_d, e4_d;
  logic [PclkW-1:0]          e16_q, e4_q;
  logic [DIVISOR_WIDTH-1:0]  d16_q, d4_q;
  logic [BaudW-1:0]          baud_q;
  logic                      v1_q;
  logic                      use4, reject;
  logic [PclkW-1:0]          err;
  logic [PclkW+ErrShift-1:0] err_sc;

  always_comb begin
    baud_x = PclkW'(baud_i);
    e16_d  = (act16_i > baud_x) ? (act16_i - baud_x) : (baud_x - act16_i);
    e4_d   = (act4_i > baud_x) ? (act4_i - baud_x) : (baud_x - act4_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e16_q  <= e16_d;
      e4_q   <= e4_d;
      d16_q  <= div16_i;
      d4_q   <= div4_i;
      baud_q <= baud_i;
    end
  end

  // A zero rate always fails this check, since any error scaled by 32 is at least zero.
  always_comb begin
    use4   = (e4_q < e16_q);
    err    = use4 ? e4_q : e16_q;
    err_sc = {err, {ErrShift{1'b0}}};
    reject = (err_sc >= (PclkW+ErrShift)'(baud_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      divisor_o    <= reject ? '0 : (use4 ? d4_q : d16_q);
      high_speed_o <= use4 & ~reject;
      status_o     <= reject;
    end
  end
endmodule

// File: hdl/uart_baud_divisor_select_unit.sv
// Top level of the UART baud divisor select block.
// A requested baud rate enters on the s_axis channel; one result item leaves on
// m_axis with the chosen divisor, the oversampling mode and the accept status.
// The peripheral clock is half of the system clock held in the configuration
// register, written through cfg_we_i/cfg_wdata_i; the user must write it only while
// no item is in flight, as the block itself does not enforce it. The pipeline is one
// input register, 31 stages of the first divider (clock over 16x and 4x rate), one
// divisor clamp register, 31 stages of the second divider (clock over the rate each
// divisor gives), and two stages of error compare and selection ending in the output
// register. Throughput is one item per cycle unless the receiver stalls; each divider
// stage resolves one quotient bit. The whole pipeline advances together whenever the
// output register is empty or its item is taken; when the receiver stalls with a
// result waiting, every stage holds and s_axis_tready drops, so nothing is lost or repeated.
// Reset clears all valid bits and loads 32000000 into the clock register.
module uart_baud_divisor_select_unit #(
  parameter int unsigned DIVISOR_WIDTH = ubds_pkg::DivWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ubds_pkg::ClkW-1:0]      cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ubds_pkg::BaudW-1:0]     s_axis_tdata,  // [23:0] baud_rate
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [((DIVISOR_WIDTH+7)/8)*8-1:0] m_axis_tdata, // divisor, zero padded
  output logic [1:0]                     m_axis_tuser   // [0] high_speed, [1] status
);
  import ubds_pkg::*;
  `include "uart_baud_divisor_select_unit_macros.svh"

  localparam int unsigned TdataW = ((DIVISOR_WIDTH+7)/8)*8;
  localparam int unsigned DenBW  = DIVISOR_WIDTH + 1 + Shift16;
  localparam logic [PclkW-1:0] QLimit = PclkW'(1) << DIVISOR_WIDTH;
  localparam int unsigned SideAW = PclkW + BaudW;
  localparam int unsigned SideBW = 2*DIVISOR_WIDTH + BaudW;

  logic              en;
  logic [ClkW-1:0]   sysclk_q;
  logic              in_v_q;
  logic [BaudW-1:0]  in_baud_q;
  logic [PclkW-1:0]  in_pclk_q;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sysclk_q <= ClockReset;
    end else if (cfg_we_i) begin
      sysclk_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_baud_q <= s_axis_tdata;
      in_pclk_q <= sysclk_q[ClkW-1:1];
    end
  end

  logic              a_v;
  logic [PclkW-1:0]  q16, q4;
  logic [SideAW-1:0] a_side;

  ubds_divider #(.NW(PclkW), .DW(DenAW), .SW(SideAW)) u_div_a (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_v_q),
    .dividend_i(in_pclk_q),
    .divisor_a_i({in_baud_q, {Shift16{1'b0}}}),
    .divisor_b_i(DenAW'({in_baud_q, {Shift4{1'b0}}})),
    .side_i({in_pclk_q, in_baud_q}),
    .valid_o(a_v), .quot_a_o(q16), .quot_b_o(q4), .side_o(a_side)
  );

  // A quotient of zero or one beyond the divisor range clamps to the largest divisor.
  logic [DIVISOR_WIDTH:0]   qc16, qc4, qm16, qm4;
  logic                     m_v_q;
  logic [DenBW-1:0]         den16_q, den4_q;
  logic [DIVISOR_WIDTH-1:0] div16_q, div4_q;
  logic [BaudW-1:0]         m_baud_q;
  logic [PclkW-1:0]         m_pclk_q;

  always_comb begin
    qc16 = (q16 != '0 && q16 <= QLimit) ? q16[DIVISOR_WIDTH:0] : QLimit[DIVISOR_WIDTH:0];
    qc4  = (q4 != '0 && q4 <= QLimit) ? q4[DIVISOR_WIDTH:0] : QLimit[DIVISOR_WIDTH:0];
    qm16 = qc16 - (DIVISOR_WIDTH+1)'(1);
    qm4  = qc4 - (DIVISOR_WIDTH+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= a_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den16_q  <= {qc16, {Shift16{1'b0}}};
      den4_q   <= DenBW'({qc4, {Shift4{1'b0}}});
      div16_q  <= qm16[DIVISOR_WIDTH-1:0];
      div4_q   <= qm4[DIVISOR_WIDTH-1:0];
      m_baud_q <= a_side[BaudW-1:0];
      m_pclk_q <= a_side[SideAW-1:BaudW];
    end
  end

  logic              b_v;
  logic [PclkW-1:0]  act16, act4;
  logic [SideBW-1:0] b_side;

  ubds_divider #(.NW(PclkW), .DW(DenBW), .SW(SideBW)) u_div_b (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m_v_q),
    .dividend_i(m_pclk_q),
    .divisor_a_i(den16_q),
    .divisor_b_i(den4_q),
    .side_i({div16_q, div4_q, m_baud_q}),
    .valid_o(b_v), .quot_a_o(act16), .quot_b_o(act4), .side_o(b_side)
  );

  logic [DIVISOR_WIDTH-1:0] divisor;
  logic                     hs, status;

  ubds_select #(.DIVISOR_WIDTH(DIVISOR_WIDTH)) u_sel (
    .clk_i, .rst_ni, .en_i(en), .valid_i(b_v),
    .act16_i(act16), .act4_i(act4),
    .div16_i(b_side[SideBW-1:BaudW+DIVISOR_WIDTH]),
    .div4_i(b_side[BaudW+DIVISOR_WIDTH-1:BaudW]),
    .baud_i(b_side[BaudW-1:0]),
    .valid_o(m_axis_tvalid), .divisor_o(divisor),
    .high_speed_o(hs), .status_o(status)
  );

  assign m_axis_tdata              = TdataW'(divisor);
  assign m_axis_tuser[TuserHs]     = hs;
  assign m_axis_tuser[TuserStatus] = status;

  `UBDS_ASSERT_IMPL(a_reject_zero, clk_i, rst_ni,
                    m_axis_tvalid && m_axis_tuser[TuserStatus],
                    m_axis_tdata == '0 && !m_axis_tuser[TuserHs],
                    "rejected item carries a nonzero divisor or mode")
  `UBDS_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !s_axis_tready,
                    m_axis_tvalid && !m_axis_tready,
                    "input stalled without a waiting result")
  // The selection stage sits two registers after the last divider stage.
  `UBDS_ASSERT(a_out_needs_pipe, clk_i, rst_ni,
               !($rose(m_axis_tvalid) && !$past(b_v, 2)),
               "result appeared without an item in the last divider stage")
endmodule
